// File: rtl/utrb_pkg.sv
// Shared types for the UART transmit block / receive ring buffer core.
// Holds the command codes, controller states and the controller-to-datapath
// command bundle. No dependencies.
package utrb_pkg;

    // Host-side command codes carried on the input beat
    typedef enum logic [1:0] {
        CMD_TX_LOAD   = 2'd0,
        CMD_TX_READY  = 2'd1,
        CMD_RX_BYTE   = 2'd2,
        CMD_HOST_READ = 2'd3
    } cmd_t;

    // Controller sequence for one beat
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_LOAD = 2'd2,
        ST_SEND = 2'd3
    } state_t;

    // Strobes from controller to datapath
    typedef struct packed {
        logic capture;  // latch the input beat
        logic exec;     // update pointers, write stores, set flags
        logic load;     // take the registered store read into byte_out
    } dp_cmd_t;

endpackage

// File: rtl/utrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module utrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/utrb_ctrl.sv
// Controller FSM: sequences each beat through execute, store read and send.
// Depends on utrb_pkg.
module utrb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output utrb_pkg::dp_cmd_t dp_cmd
);
    import utrb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SEND;
            ST_SEND:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        dp_cmd.capture = 1'b0;
        dp_cmd.exec    = 1'b0;
        dp_cmd.load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                dp_cmd.capture = in_valid;
            end
            ST_EXEC: dp_cmd.exec = 1'b1;
            ST_LOAD: dp_cmd.load = 1'b1;
            ST_SEND: out_valid = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

endmodule

// File: rtl/utrb_dp.sv
// Datapath: transmit message store and counters, receive ring and pointers,
// result registers. Depends on utrb_pkg and utrb_ram.
module utrb_dp #(
    parameter int TX_DEPTH = 128,
    parameter int RX_DEPTH = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  utrb_pkg::dp_cmd_t dp_cmd,
    input  logic [1:0]        cmd,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              accepted,
    output logic              byte_valid,
    output logic [7:0]        byte_out,
    output logic              tx_done,
    output logic              tx_busy,
    output logic [6:0]        rx_level
);
    import utrb_pkg::*;

    localparam int TX_AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CW = $clog2(TX_DEPTH + 1);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [RX_AW:0]   RX_SPAN = (RX_AW + 1)'(RX_DEPTH);

    // Latched input beat
    cmd_t       cmd_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // Transmit and receive control state
    logic [TX_CW-1:0] tx_fill_reg, tx_fill_next;
    logic [TX_CW-1:0] tx_pos_reg,  tx_pos_next;
    logic [TX_CW-1:0] tx_len_reg,  tx_len_next;
    logic             tx_active_reg, tx_active_next;
    logic [RX_AW-1:0] rx_wr_reg, rx_wr_next;
    logic [RX_AW-1:0] rx_rd_reg, rx_rd_next;

    // Result flags
    logic accepted_reg, accepted_next;
    logic valid_reg,    valid_next;
    logic done_reg,     done_next;
    logic src_rx_reg,   src_rx_next;
    logic [7:0] byte_out_reg;

    // Store ports
    logic             tx_we;
    logic             rx_we;
    logic [7:0]       tx_rdata;
    logic [7:0]       rx_rdata;
    logic [RX_AW-1:0] rx_wr_inc;
    logic [RX_AW-1:0] rx_rd_inc;
    logic [RX_AW:0]   rx_diff;

    utrb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_fill_reg[TX_AW-1:0]),
        .wdata (data_reg),
        .raddr (tx_pos_reg[TX_AW-1:0]),
        .rdata (tx_rdata)
    );

    utrb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wr_reg),
        .wdata (data_reg),
        .raddr (rx_rd_reg),
        .rdata (rx_rdata)
    );

    // Ring pointer increments with wrap
    assign rx_wr_inc = (rx_wr_reg == RX_LAST) ? '0 : rx_wr_reg + 1'b1;
    assign rx_rd_inc = (rx_rd_reg == RX_LAST) ? '0 : rx_rd_reg + 1'b1;

    // Beat execution
    always_comb
    begin
        tx_fill_next   = tx_fill_reg;
        tx_pos_next    = tx_pos_reg;
        tx_len_next    = tx_len_reg;
        tx_active_next = tx_active_reg;
        rx_wr_next     = rx_wr_reg;
        rx_rd_next     = rx_rd_reg;
        accepted_next  = 1'b0;
        valid_next     = 1'b0;
        done_next      = 1'b0;
        src_rx_next    = 1'b0;
        tx_we          = 1'b0;
        rx_we          = 1'b0;
        if (dp_cmd.exec)
        begin
            unique case (cmd_reg)
                CMD_TX_LOAD:
                begin
                    if (!tx_active_reg)
                    begin
                        if (tx_fill_reg >= TX_FULL)
                        begin
                            // overflow: drop the partial message
                            tx_fill_next = '0;
                        end
                        else
                        begin
                            tx_we         = 1'b1;
                            accepted_next = 1'b1;
                            tx_fill_next  = tx_fill_reg + 1'b1;
                            if (last_reg)
                            begin
                                tx_len_next    = tx_fill_reg + 1'b1;
                                tx_pos_next    = '0;
                                tx_active_next = 1'b1;
                                tx_fill_next   = '0;
                            end
                        end
                    end
                end
                CMD_TX_READY:
                begin
                    if (tx_active_reg)
                    begin
                        if (tx_pos_reg < tx_len_reg && tx_pos_reg < TX_FULL)
                        begin
                            tx_pos_next   = tx_pos_reg + 1'b1;
                            valid_next    = 1'b1;
                            accepted_next = 1'b1;
                        end
                        else
                        begin
                            // message exhausted: free the buffer
                            done_next      = 1'b1;
                            tx_active_next = 1'b0;
                            tx_pos_next    = '0;
                            tx_len_next    = '0;
                        end
                    end
                end
                CMD_RX_BYTE:
                begin
                    if (rx_wr_inc != rx_rd_reg)
                    begin
                        rx_we         = 1'b1;
                        rx_wr_next    = rx_wr_inc;
                        accepted_next = 1'b1;
                    end
                end
                CMD_HOST_READ:
                begin
                    if (rx_rd_reg != rx_wr_reg)
                    begin
                        rx_rd_next    = rx_rd_inc;
                        valid_next    = 1'b1;
                        accepted_next = 1'b1;
                        src_rx_next   = 1'b1;
                    end
                end
                default: accepted_next = 1'b0;
            endcase
        end
    end

    // Control state and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_fill_reg   <= '0;
            tx_pos_reg    <= '0;
            tx_len_reg    <= '0;
            tx_active_reg <= 1'b0;
            rx_wr_reg     <= '0;
            rx_rd_reg     <= '0;
            accepted_reg  <= 1'b0;
            valid_reg     <= 1'b0;
            done_reg      <= 1'b0;
            src_rx_reg    <= 1'b0;
        end
        else if (dp_cmd.exec)
        begin
            tx_fill_reg   <= tx_fill_next;
            tx_pos_reg    <= tx_pos_next;
            tx_len_reg    <= tx_len_next;
            tx_active_reg <= tx_active_next;
            rx_wr_reg     <= rx_wr_next;
            rx_rd_reg     <= rx_rd_next;
            accepted_reg  <= accepted_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
            src_rx_reg    <= src_rx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd_t'(cmd);
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (dp_cmd.load)
        begin
            byte_out_reg <= !valid_reg ? 8'd0 : (src_rx_reg ? rx_rdata : tx_rdata);
        end
    end

    // Ring occupancy
    always_comb
    begin
        if (rx_wr_reg >= rx_rd_reg)
        begin
            rx_diff = {1'b0, rx_wr_reg} - {1'b0, rx_rd_reg};
        end
        else
        begin
            rx_diff = {1'b0, rx_wr_reg} + RX_SPAN - {1'b0, rx_rd_reg};
        end
    end

    assign accepted   = accepted_reg;
    assign byte_valid = valid_reg;
    assign byte_out   = byte_out_reg;
    assign tx_done    = done_reg;
    assign tx_busy    = tx_active_reg;
    assign rx_level   = 7'(rx_diff);

endmodule

// File: rtl/uart_tx_block_and_rx_ring_buffer_core.sv
// UART transmit message block and receive ring buffer, top level.
// Depends on utrb_pkg, utrb_ctrl, utrb_dp (which holds two utrb_ram).
//
// Input channel (in_valid/in_ready) carries one command beat: cmd, data_byte,
// last_byte. Command 0 loads a transmit byte (last_byte closes the message),
// 1 is a transmitter-ready event, 2 pushes a received byte into the ring,
// 3 is a host read that pops the ring.
// Output channel (out_valid/out_ready) returns exactly one result beat per
// input beat: accepted, byte_valid, byte_out (0 unless byte_valid), tx_done,
// tx_busy and rx_level as they stand after the command.
// Sequencing: the result is offered once the beat has been executed and the
// store read has been taken into the result register (EXEC, then LOAD, then
// SEND). One beat is in flight at a time, so a new beat is taken only after
// the result is taken and the controller has gone back to IDLE.
// The registered read of the message and ring stores sets the store-read cycle.
// Reset clears all counters, pointers and flags; store contents are left as
// they are and never read before being written.
// While the receiver holds out_ready low the result stays unchanged and
// in_ready stays low.
module uart_tx_block_and_rx_ring_buffer_core #(
    parameter int TX_DEPTH = 128,
    parameter int RX_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       accepted,
    output logic       byte_valid,
    output logic [7:0] byte_out,
    output logic       tx_done,
    output logic       tx_busy,
    output logic [6:0] rx_level
);
    import utrb_pkg::*;

    dp_cmd_t dp_cmd;

    utrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    utrb_dp #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .accepted   (accepted),
        .byte_valid (byte_valid),
        .byte_out   (byte_out),
        .tx_done    (tx_done),
        .tx_busy    (tx_busy),
        .rx_level   (rx_level)
    );

endmodule

// File: rtl/utrb_chk.sv
// Port-level checker for the UART transmit / receive buffer core, with bind.
// Depends on uart_tx_block_and_rx_ring_buffer_core port names only.
module utrb_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       accepted,
    input logic       byte_valid,
    input logic [7:0] byte_out,
    input logic       tx_done,
    input logic       tx_busy,
    input logic [6:0] rx_level
);

    // one beat in flight: never ready for input while a result is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    // a byte handed out always counts as accepted
    a_valid_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> accepted)
        else $error("byte_valid without accepted");

    // no byte means a zero byte field
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (byte_out == 8'd0))
        else $error("byte_out nonzero without byte_valid");

    // done frees the buffer and is never an accept
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_done) |-> (!accepted && !tx_busy && !byte_valid))
        else $error("tx_done with busy or accepted");

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(byte_out) && $stable(rx_level) && $stable(accepted)))
        else $error("result changed while stalled");

endmodule

bind uart_tx_block_and_rx_ring_buffer_core utrb_chk u_utrb_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for uart_tx_block_and_rx_ring_buffer_core.
// Needs utrb_pkg and the core RTL. An internal buffer predictor checks every result beat.
module tb_top;
    import utrb_pkg::*;

    localparam int TX_DEPTH     = 128;
    localparam int RX_DEPTH     = 128;
    localparam int RING_CAP     = RX_DEPTH - 1;
    localparam int DIRECTED     = 21;
    localparam int RANDOM_BEATS = 1900;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 12;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       last;
        logic       quiesce;   // hold this beat until no result is outstanding
    } host_beat_t;

    typedef struct packed {
        logic       accepted;
        logic       byte_valid;
        logic [7:0] byte_out;
        logic       tx_done;
        logic       tx_busy;
        logic [6:0] rx_level;
    } buf_result_t;

    // DUT ports
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] cmd = '0;
    logic [7:0] data_byte = '0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       accepted;
    logic       byte_valid;
    logic [7:0] byte_out;
    logic       tx_done;
    logic       tx_busy;
    logic [6:0] rx_level;

    // Stimulus backlog and expected results
    host_beat_t  cmd_backlog[$];
    buf_result_t pending_results[$];

    // Predictor state
    logic [7:0] msg_bytes [TX_DEPTH];
    int         msg_fill = 0;
    int         msg_pos = 0;
    int         msg_len = 0;
    bit         msg_held = 1'b0;
    logic [7:0] ring_bytes [RX_DEPTH];
    int         ring_wr = 0;
    int         ring_rd = 0;

    // Coverage tallies for the summary
    int n_sent = 0, n_popped = 0, n_done = 0, n_load_rej = 0;
    int n_rx_drop = 0, n_read_empty = 0, ring_peak = 0;
    int results_seen = 0, errors = 0;

    // Generator-side view of the block, used only to shape sequences
    bit gen_held = 1'b0;
    int gen_fill = 0;
    int gen_left = 0;
    int gen_level = 0;
    int live_beats = 0;
    bit hold_next = 1'b0;

    // Driver / monitor bookkeeping
    bit          beat_taken = 1'b0;
    int          in_gap = 0;
    int          out_stall = 0;
    bit          in_steady = 1'b0;
    bit          out_steady = 1'b0;
    int          idle_cycles = 0;
    host_beat_t  next_beat;
    host_beat_t  seen_beat;
    buf_result_t want;

    uart_tx_block_and_rx_ring_buffer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accepted   (accepted),
        .byte_valid (byte_valid),
        .byte_out   (byte_out),
        .tx_done    (tx_done),
        .tx_busy    (tx_busy),
        .rx_level   (rx_level)
    );

    always #5 clk = ~clk;

    // Expected result of one host beat; advances the predictor state
    function automatic buf_result_t buffer_step(host_beat_t b);
        buf_result_t r;
        int nxt;
        r = '0;
        case (b.cmd)
            CMD_TX_LOAD:
            begin
                if (msg_held)
                    n_load_rej++;
                else if (msg_fill >= TX_DEPTH)
                begin
                    // overlong message: drop the partial
                    msg_fill = 0;
                    n_load_rej++;
                end
                else
                begin
                    msg_bytes[msg_fill] = b.data;
                    msg_fill++;
                    r.accepted = 1'b1;
                    if (b.last)
                    begin
                        msg_len  = msg_fill;
                        msg_pos  = 0;
                        msg_held = 1'b1;
                        msg_fill = 0;
                    end
                end
            end
            CMD_TX_READY:
            begin
                if (msg_held)
                begin
                    if (msg_pos < msg_len)
                    begin
                        r.byte_out   = msg_bytes[msg_pos];
                        r.byte_valid = 1'b1;
                        r.accepted   = 1'b1;
                        msg_pos++;
                        n_sent++;
                    end
                    else
                    begin
                        // message exhausted: report done, free the buffer
                        r.tx_done = 1'b1;
                        msg_held  = 1'b0;
                        msg_pos   = 0;
                        msg_len   = 0;
                        n_done++;
                    end
                end
            end
            CMD_RX_BYTE:
            begin
                nxt = (ring_wr + 1 >= RX_DEPTH) ? 0 : ring_wr + 1;
                if (nxt != ring_rd)
                begin
                    ring_bytes[ring_wr] = b.data;
                    ring_wr    = nxt;
                    r.accepted = 1'b1;
                end
                else
                    n_rx_drop++;
            end
            default:
            begin
                if (ring_rd != ring_wr)
                begin
                    r.byte_out   = ring_bytes[ring_rd];
                    r.byte_valid = 1'b1;
                    r.accepted   = 1'b1;
                    ring_rd      = (ring_rd + 1 >= RX_DEPTH) ? 0 : ring_rd + 1;
                    n_popped++;
                end
                else
                    n_read_empty++;
            end
        endcase
        r.tx_busy  = msg_held;
        r.rx_level = 7'((ring_wr + RX_DEPTH - ring_rd) % RX_DEPTH);
        if (int'(r.rx_level) > ring_peak)
            ring_peak = r.rx_level;
        return r;
    endfunction

    // Queue one host beat and track the block roughly for sequence shaping
    task automatic push_beat(cmd_t c, logic [7:0] d, logic l);
        host_beat_t b;
        b.cmd     = c;
        b.data    = d;
        b.last    = l;
        b.quiesce = hold_next;
        hold_next = 1'b0;
        cmd_backlog.push_back(b);
        if (!(c == CMD_TX_READY && !gen_held))
            live_beats++;
        case (c)
            CMD_TX_LOAD:
            begin
                if (!gen_held)
                begin
                    if (gen_fill >= TX_DEPTH)
                        gen_fill = 0;
                    else
                    begin
                        gen_fill++;
                        if (l)
                        begin
                            gen_held = 1'b1;
                            gen_left = gen_fill;
                            gen_fill = 0;
                        end
                    end
                end
            end
            CMD_TX_READY:
            begin
                if (gen_held)
                begin
                    if (gen_left > 0)
                        gen_left--;
                    else
                        gen_held = 1'b0;
                end
            end
            CMD_RX_BYTE:
            begin
                if (gen_level < RING_CAP)
                    gen_level++;
            end
            default:
            begin
                if (gen_level > 0)
                    gen_level--;
            end
        endcase
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1, 0));
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 45)
            return 0;
        else if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(80, 20);
    endfunction

    // Send out the rest of a held message, through the done event
    task automatic finish_message();
        while (gen_held)
            push_beat(CMD_TX_READY, rand_byte(), rand_bit());
    endtask

    task automatic load_message(int n);
        for (int i = 0; i < n; i++)
            push_beat(CMD_TX_LOAD, rand_byte(), logic'(i == n - 1));
    endtask

    // Loads with no last byte until the message runs past TX_DEPTH
    task automatic overflow_run();
        finish_message();
        while (gen_fill < TX_DEPTH)
            push_beat(CMD_TX_LOAD, rand_byte(), 1'b0);
        push_beat(CMD_TX_LOAD, rand_byte(), 1'b0);
        load_message($urandom_range(3, 1));
    endtask

    // Fill the ring to capacity, then two receives that get dropped
    task automatic fill_ring();
        while (gen_level < RING_CAP)
            push_beat(CMD_RX_BYTE, rand_byte(), rand_bit());
        repeat (2)
            push_beat(CMD_RX_BYTE, rand_byte(), rand_bit());
    endtask

    task automatic drain_ring();
        repeat (gen_level + 2)
            push_beat(CMD_HOST_READ, rand_byte(), rand_bit());
    endtask

    task automatic check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_val, got_val);
        end
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        int pick, sz, k;

        // directed: empty ring and idle transmitter
        push_beat(CMD_HOST_READ, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        // ring round trip with extreme bytes, then empty again
        push_beat(CMD_RX_BYTE, 8'h00, 1'b0);
        push_beat(CMD_RX_BYTE, 8'hFF, 1'b1);
        push_beat(CMD_RX_BYTE, 8'hA5, 1'b0);
        push_beat(CMD_HOST_READ, 8'hFF, 1'b1);
        push_beat(CMD_HOST_READ, 8'h00, 1'b0);
        push_beat(CMD_HOST_READ, 8'h00, 1'b0);
        push_beat(CMD_HOST_READ, 8'h00, 1'b0);
        // three-byte message, a load while it is sending, then send it out
        push_beat(CMD_TX_LOAD, 8'hFF, 1'b0);
        push_beat(CMD_TX_LOAD, 8'h00, 1'b0);
        push_beat(CMD_TX_LOAD, 8'h5A, 1'b1);
        push_beat(CMD_TX_LOAD, 8'h11, 1'b1);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'hFF, 1'b1);
        // single-byte message
        push_beat(CMD_TX_LOAD, 8'h80, 1'b1);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);
        push_beat(CMD_TX_READY, 8'h00, 1'b0);

        // quiet point, then one overlong message and one full ring up front
        hold_next = 1'b1;
        overflow_run();
        fill_ring();
        drain_ring();

        while (live_beats < DIRECTED + RANDOM_BEATS)
        begin
            pick = $urandom_range(99, 0);
            if ($urandom_range(99, 0) == 0)
                hold_next = 1'b1;
            if (pick < 35)
            begin
                // new message, partly or fully sent with ring traffic mixed in
                if (gen_held && $urandom_range(3, 0) != 0)
                    finish_message();
                k = $urandom_range(99, 0);
                if (k < 85)
                    sz = $urandom_range(6, 1);
                else if (k < 97)
                    sz = $urandom_range(40, 7);
                else
                    sz = (gen_fill < TX_DEPTH) ? TX_DEPTH - gen_fill : 1;
                load_message(sz);
                k = $urandom_range(sz + 1, 0);
                for (int j = 0; j < k; j++)
                begin
                    if ($urandom_range(3, 0) == 0)
                        push_beat(cmd_t'($urandom_range(3, 2)), rand_byte(), rand_bit());
                    else
                        push_beat(CMD_TX_READY, rand_byte(), rand_bit());
                end
            end
            else if (pick < 45)
            begin
                k = $urandom_range(8, 1);
                for (int j = 0; j < k; j++)
                    push_beat(CMD_TX_READY, rand_byte(), rand_bit());
            end
            else if (pick < 75)
            begin
                // receive/read mix, biased away from the ends of the ring
                k = $urandom_range(12, 1);
                for (int j = 0; j < k; j++)
                begin
                    sz = (gen_level < 4) ? 70 : (gen_level > 120) ? 30 : 50;
                    if ($urandom_range(99, 0) < sz)
                        push_beat(CMD_RX_BYTE, rand_byte(), rand_bit());
                    else
                        push_beat(CMD_HOST_READ, rand_byte(), rand_bit());
                end
            end
            else if (pick < 77)
                fill_ring();
            else if (pick < 79)
                drain_ring();
            else if (pick < 80)
                overflow_run();
            else
            begin
                // noise: anything in any field
                k = $urandom_range(6, 1);
                for (int j = 0; j < k; j++)
                    push_beat(cmd_t'($urandom_range(3, 0)), rand_byte(), rand_bit());
            end
        end
        finish_message();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("covered %0d results: %0d bytes sent, %0d messages done, %0d loads rejected",
                 results_seen, n_sent, n_done, n_load_rej);
        $display("ring: %0d popped, %0d dropped when full, %0d empty reads, peak level %0d",
                 n_popped, n_rx_drop, n_read_empty, ring_peak);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Driver: new beats and ready changes at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(399, 0) == 0)
                in_steady = !in_steady;
            if ($urandom_range(399, 0) == 0)
                out_steady = !out_steady;

            if (!in_valid || beat_taken)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].quiesce && pending_results.size() != 0))
                begin
                    next_beat = cmd_backlog.pop_front();
                    in_valid  <= 1'b1;
                    cmd       <= next_beat.cmd;
                    data_byte <= next_beat.data;
                    last_byte <= next_beat.last;
                    in_gap = in_steady ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end

            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!out_steady && $urandom_range(2, 0) == 0)
                    out_stall = pick_gap();
            end
        end
    end

    // Monitor: predict on each input beat, check each result beat, watchdog
    always @(posedge clk)
    begin
        beat_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                beat_taken        = 1'b1;
                seen_beat.cmd     = cmd_t'(cmd);
                seen_beat.data    = data_byte;
                seen_beat.last    = last_byte;
                seen_beat.quiesce = 1'b0;
                pending_results.push_back(buffer_step(seen_beat));
            end

            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_seen++;
                    check_field("accepted", want.accepted, accepted);
                    check_field("byte_valid", want.byte_valid, byte_valid);
                    check_field("byte_out", want.byte_out, byte_out);
                    check_field("tx_done", want.tx_done, tx_done);
                    check_field("tx_busy", want.tx_busy, tx_busy);
                    check_field("rx_level", want.rx_level, rx_level);
                end
            end

            if (beat_taken || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, pending_results.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
